// File: hw/rtl/assert_macros.svh
// assertion macros used by the ready-queue rtl
// clocked on clk_i of the including module; PRQ_ASSERT is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check outside of reset
`define PRQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check that also holds while reset is applied
`define PRQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/prq_pkg.sv
// prq_pkg: widths, codes and types of the priority ready queue
// no dependencies
`default_nettype none

package prq_pkg;

  // field widths
  localparam int KIND_W  = 2;
  localparam int TASK_W  = 7;
  localparam int LEVEL_W = 5;
  localparam int MAP_W   = 32;

  // storage depths follow from the field widths
  localparam int NUM_TASKS  = 2 ** TASK_W;
  localparam int NUM_LEVELS = 2 ** LEVEL_W;

  typedef logic [KIND_W-1:0]     kind_t;
  typedef logic [TASK_W-1:0]     tid_t;
  typedef logic [LEVEL_W-1:0]    level_t;
  typedef logic [NUM_LEVELS-1:0] map_t;

  // request codes
  localparam kind_t KIND_PUSH      = 2'd0;
  localparam kind_t KIND_POP_TOP   = 2'd1;
  localparam kind_t KIND_POP_LEVEL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_LINK
  } state_e;

  // per-level entry: newest task (head) and oldest task (tail)
  typedef struct packed {
    tid_t head;
    tid_t tail;
  } lvl_entry_t;

  // per-task link: valid flag over the next newer task
  typedef struct packed {
    logic valid;
    tid_t next;
  } link_entry_t;

  // result of the lowest-set-bit search
  typedef struct packed {
    logic   any;
    level_t idx;
  } lowest_t;

endpackage

`default_nettype wire

// File: hw/rtl/prq_if.sv
// prq_req_if / prq_rsp_if: request and response channels of the ready queue
// depends on prq_pkg
`default_nettype none

interface prq_req_if;
  logic            valid;
  logic            ready;
  prq_pkg::kind_t  kind;
  prq_pkg::tid_t   task_id;
  prq_pkg::level_t level;

  modport source (output valid, output kind, output task_id, output level, input ready);
  modport sink   (input valid, input kind, input task_id, input level, output ready);
endinterface

interface prq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  prq_pkg::tid_t              out_task;
  prq_pkg::level_t            out_level;
  logic [prq_pkg::MAP_W-1:0]  busy_levels;

  modport source (output valid, output found, output out_task, output out_level,
                  output busy_levels, input ready);
  modport sink   (input valid, input found, input out_task, input out_level,
                  input busy_levels, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/prq_prio_enc.sv
// prq_prio_enc: finds the most urgent (lowest numbered) non-empty level
// depends on prq_pkg
`default_nettype none

module prq_prio_enc (
  input  prq_pkg::map_t    map_i,
  output prq_pkg::lowest_t lowest_o
);

  // scan from the top so the lowest set bit wins
  always_comb begin
    lowest_o.any = |map_i;
    lowest_o.idx = '0;
    for (int i = prq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (map_i[i]) begin
        lowest_o.idx = prq_pkg::LEVEL_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/priority_ready_queue.sv
// priority_ready_queue: 32-level fifo ready queue with a non-empty level bitmap
// depends on prq_pkg, prq_if, prq_prio_enc and assert_macros.svh
//
//   channel  dir  beat fields
//   req_i    in   kind, task_id, level
//   rsp_o    out  found, out_task, out_level, busy_levels
//
// a push reads the level memory and clears its link, then writes back head/tail and link
// a pop reads the level memory, then the link memory, then writes back
// a request that finds nothing is answered straight from idle
// one request is worked at a time; a response beat held by the sink holds off the next request
// reset clears only the bitmap and control; memories need no clearing pass
`default_nettype none

`include "assert_macros.svh"

module priority_ready_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  prq_req_if.sink          req_i,
  prq_rsp_if.source        rsp_o
);

  // control state
  prq_pkg::state_e state_q, state_d;
  prq_pkg::map_t   map_q, map_d;
  logic            is_push_q, is_push_d;
  prq_pkg::tid_t   tid_q, tid_d;
  prq_pkg::level_t lv_q, lv_d;

  // result register
  logic                      out_valid_q, out_valid_d;
  logic                      found_q, found_d;
  prq_pkg::tid_t             out_task_q, out_task_d;
  prq_pkg::level_t           out_level_q, out_level_d;
  prq_pkg::map_t             busy_q, busy_d;

  // level memory ports
  prq_pkg::lvl_entry_t level_mem [prq_pkg::NUM_LEVELS];
  logic                lvl_re, lvl_we;
  prq_pkg::level_t     lvl_raddr, lvl_waddr;
  prq_pkg::lvl_entry_t lvl_wdata, lvl_rdata_q;

  // link memory ports
  prq_pkg::link_entry_t link_mem [prq_pkg::NUM_TASKS];
  logic                 link_re, link_we;
  prq_pkg::tid_t        link_raddr, link_waddr;
  prq_pkg::link_entry_t link_wdata, link_rdata_q;

  prq_pkg::lowest_t lowest;
  logic             accept;
  logic             hit;
  prq_pkg::level_t  sel_lv;

  prq_prio_enc u_prio_enc (
    .map_i    (map_q),
    .lowest_o (lowest)
  );

  // level memory, registered read
  always_ff @(posedge clk_i) begin
    if (lvl_we) begin
      level_mem[lvl_waddr] <= lvl_wdata;
    end
    if (lvl_re) begin
      lvl_rdata_q <= level_mem[lvl_raddr];
    end
  end

  // link memory, registered read
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata_q <= link_mem[link_raddr];
    end
  end

  // handshake
  assign req_i.ready = (state_q == prq_pkg::ST_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.out_task    = out_task_q;
  assign rsp_o.out_level   = out_level_q;
  assign rsp_o.busy_levels = prq_pkg::MAP_W'(busy_q);

  // request decode: level to work on and whether there is anything to do
  always_comb begin
    hit    = 1'b0;
    sel_lv = req_i.level;
    unique case (req_i.kind)
      prq_pkg::KIND_PUSH: begin
        hit = 1'b1;
      end
      prq_pkg::KIND_POP_TOP: begin
        hit    = lowest.any;
        sel_lv = lowest.idx;
      end
      prq_pkg::KIND_POP_LEVEL: begin
        hit = map_q[req_i.level];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // sequencer: read level entry, then update links, head, tail and bitmap
  always_comb begin
    state_d          = state_q;
    map_d            = map_q;
    is_push_d        = is_push_q;
    tid_d            = tid_q;
    lv_d             = lv_q;
    out_valid_d      = out_valid_q && !rsp_o.ready;
    found_d          = found_q;
    out_task_d       = out_task_q;
    out_level_d      = out_level_q;
    busy_d           = busy_q;
    lvl_re           = 1'b0;
    lvl_we           = 1'b0;
    lvl_raddr        = sel_lv;
    lvl_waddr        = lv_q;
    lvl_wdata        = lvl_rdata_q;
    link_re          = 1'b0;
    link_we          = 1'b0;
    link_raddr       = lvl_rdata_q.tail;
    link_waddr       = lvl_rdata_q.head;
    link_wdata.valid = 1'b1;
    link_wdata.next  = tid_q;

    unique case (state_q)
      prq_pkg::ST_IDLE: begin
        if (accept) begin
          if (hit) begin
            lvl_re    = 1'b1;
            is_push_d = (req_i.kind == prq_pkg::KIND_PUSH);
            tid_d     = req_i.task_id;
            lv_d      = sel_lv;
            state_d   = prq_pkg::ST_LEVEL;
            // a pushed task starts with no newer link
            if (req_i.kind == prq_pkg::KIND_PUSH) begin
              link_we    = 1'b1;
              link_waddr = req_i.task_id;
              link_wdata = '0;
            end
          end else begin
            out_valid_d = 1'b1;
            found_d     = 1'b0;
            out_task_d  = '0;
            out_level_d = '0;
            busy_d      = map_q;
          end
        end
      end

      prq_pkg::ST_LEVEL: begin
        if (is_push_q) begin
          // append at head; an empty level starts with head and tail equal
          lvl_we         = 1'b1;
          lvl_wdata.head = tid_q;
          if (map_q[lv_q]) begin
            // relinking the newest task to itself leaves its link cleared
            link_we = (lvl_rdata_q.head != tid_q);
          end else begin
            lvl_wdata.tail = tid_q;
            map_d[lv_q]    = 1'b1;
          end
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          out_task_d  = '0;
          out_level_d = '0;
          busy_d      = map_d;
          state_d     = prq_pkg::ST_IDLE;
        end else begin
          link_re = 1'b1;
          state_d = prq_pkg::ST_LINK;
        end
      end

      prq_pkg::ST_LINK: begin
        // oldest task leaves; its link is cleared
        link_we    = 1'b1;
        link_waddr = lvl_rdata_q.tail;
        link_wdata = '0;
        lvl_we     = 1'b1;
        if (link_rdata_q.valid) begin
          // tail moves to the next newer task
          lvl_wdata.tail = link_rdata_q.next;
        end else begin
          // last task of the level leaves
          lvl_wdata   = '0;
          map_d[lv_q] = 1'b0;
        end
        out_valid_d = 1'b1;
        found_d     = 1'b1;
        out_task_d  = lvl_rdata_q.tail;
        out_level_d = lv_q;
        busy_d      = map_d;
        state_d     = prq_pkg::ST_IDLE;
      end

      default: begin
        state_d = prq_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prq_pkg::ST_IDLE;
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      map_q       <= map_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    is_push_q   <= is_push_d;
    tid_q       <= tid_d;
    lv_q        <= lv_d;
    found_q     <= found_d;
    out_task_q  <= out_task_d;
    out_level_q <= out_level_d;
    busy_q      <= busy_d;
  end

  // assertions
  `PRQ_ASSERT(a_link_after_level, (state_q == prq_pkg::ST_LINK) |-> ($past(state_q) == prq_pkg::ST_LEVEL), "link read without level read")
  `PRQ_ASSERT(a_pop_level_busy, (state_q == prq_pkg::ST_LEVEL && !is_push_q) |-> map_q[lv_q], "pop works on an empty level")
  `PRQ_ASSERT(a_no_result_overrun, (req_i.valid && req_i.ready) |-> (!out_valid_q || rsp_o.ready), "request taken while result is stuck")
  `PRQ_ASSERT(a_one_mem_write_level, (lvl_we && lvl_re) |-> 1'b0, "level memory read and written together")
  `PRQ_ASSERT_ALWAYS(a_reset_no_result, !rst_ni |-> !out_valid_q, "result valid during reset")

endmodule

`default_nettype wire

// File: verif/priority_ready_queue_tb.sv
// priority_ready_queue_tb: self-checking bench for the 32-level ready queue
// depends on prq_pkg, prq_if and the priority_ready_queue rtl
`timescale 1ns / 100ps

module priority_ready_queue_tb;

  localparam int   CLK_HALF    = 4;
  localparam int   RESET_CYCLES = 10;
  localparam int   RANDOM_REQS = 400;
  localparam int   DRAIN_EVERY = 100;
  localparam int   MAX_QUEUED  = 100;
  localparam int   TAIL_CYCLES = 10;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   MAX_IDLE    = 15;

  // request code the block must ignore
  localparam prq_pkg::kind_t KIND_UNUSED = 2'd3;
  // link entry: valid flag over the next newer task
  localparam logic  LINK_SET    = 1'b1;
  localparam int    LINK_FLAG   = prq_pkg::TASK_W;

  typedef struct packed {
    prq_pkg::kind_t  kind;
    prq_pkg::tid_t   task_id;
    prq_pkg::level_t level;
  } sched_req_t;

  typedef struct packed {
    logic                      found;
    prq_pkg::tid_t             out_task;
    prq_pkg::level_t           out_level;
    logic [prq_pkg::MAP_W-1:0] busy;
  } sched_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;

  // driven copies of the channel controls, known from time zero
  logic            drv_valid   = 1'b0;
  prq_pkg::kind_t  drv_kind    = prq_pkg::KIND_PUSH;
  prq_pkg::tid_t   drv_task    = '0;
  prq_pkg::level_t drv_level   = '0;
  logic            sink_ready  = 1'b0;

  prq_req_if req_bus ();
  prq_rsp_if rsp_bus ();

  assign req_bus.valid   = drv_valid;
  assign req_bus.kind    = drv_kind;
  assign req_bus.task_id = drv_task;
  assign req_bus.level   = drv_level;
  assign rsp_bus.ready   = sink_ready;

  priority_ready_queue u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------
  // predicted queue state
  // ---------------------------------------------------------------
  prq_pkg::tid_t             lvl_newest [prq_pkg::NUM_LEVELS];
  prq_pkg::tid_t             lvl_oldest [prq_pkg::NUM_LEVELS];
  logic [prq_pkg::TASK_W:0]  next_link  [prq_pkg::NUM_TASKS];
  logic [prq_pkg::MAP_W-1:0] ready_map;

  // lowest numbered non-empty level, i.e. the most urgent one
  function automatic prq_pkg::level_t most_urgent(logic [prq_pkg::MAP_W-1:0] m);
    prq_pkg::level_t r;
    r = '0;
    for (int i = prq_pkg::NUM_LEVELS - 1; i >= 0; i--) begin
      if (m[i]) r = prq_pkg::level_t'(i);
    end
    return r;
  endfunction

  // apply one request to the predicted state and return its result
  function automatic sched_result_t schedule_step(prq_pkg::kind_t k, prq_pkg::tid_t t,
                                                  prq_pkg::level_t lv);
    sched_result_t   r;
    prq_pkg::level_t pick;
    logic            do_pop;
    prq_pkg::tid_t   victim;
    r      = '0;
    do_pop = 1'b0;
    pick   = lv;
    case (k)
      prq_pkg::KIND_PUSH: begin
        if (ready_map[lv]) begin
          next_link[lvl_newest[lv]] = {LINK_SET, t};
        end else begin
          ready_map[lv]  = 1'b1;
          lvl_oldest[lv] = t;
        end
        lvl_newest[lv] = t;
        next_link[t]   = '0;
        r.found        = 1'b1;
      end
      prq_pkg::KIND_POP_TOP: begin
        do_pop = |ready_map;
        pick   = most_urgent(ready_map);
      end
      prq_pkg::KIND_POP_LEVEL: begin
        do_pop = ready_map[lv];
      end
      default: ;
    endcase
    // unlink the oldest task of the chosen level
    if (do_pop) begin
      victim = lvl_oldest[pick];
      if (next_link[victim][LINK_FLAG]) begin
        lvl_oldest[pick] = next_link[victim][prq_pkg::TASK_W-1:0];
      end else begin
        ready_map[pick]  = 1'b0;
        lvl_newest[pick] = '0;
        lvl_oldest[pick] = '0;
      end
      next_link[victim] = '0;
      r.found     = 1'b1;
      r.out_task  = victim;
      r.out_level = pick;
    end
    r.busy = ready_map;
    return r;
  endfunction

  // ---------------------------------------------------------------
  // stimulus shaping: rough occupancy shadow, only steers the choices
  // ---------------------------------------------------------------
  sched_req_t    pending_reqs [$];
  prq_pkg::tid_t lane_tasks [prq_pkg::NUM_LEVELS][$];
  logic          task_queued [prq_pkg::NUM_TASKS];
  int            queued_total = 0;

  task automatic add_request(prq_pkg::kind_t k, prq_pkg::tid_t t, prq_pkg::level_t lv);
    sched_req_t rq;
    int         idx;
    rq.kind    = k;
    rq.task_id = t;
    rq.level   = lv;
    idx        = -1;
    pending_reqs.push_back(rq);
    case (k)
      prq_pkg::KIND_PUSH: begin
        lane_tasks[lv].push_back(t);
        task_queued[t] = 1'b1;
        queued_total++;
      end
      prq_pkg::KIND_POP_TOP: begin
        for (int i = 0; i < prq_pkg::NUM_LEVELS; i++) begin
          if (idx < 0 && lane_tasks[i].size() > 0) idx = i;
        end
        if (idx >= 0) begin
          task_queued[lane_tasks[idx].pop_front()] = 1'b0;
          queued_total--;
        end
      end
      prq_pkg::KIND_POP_LEVEL: begin
        if (lane_tasks[lv].size() > 0) begin
          task_queued[lane_tasks[lv].pop_front()] = 1'b0;
          queued_total--;
        end
      end
      default: ;
    endcase
  endtask

  function automatic prq_pkg::tid_t pick_idle_task();
    prq_pkg::tid_t t;
    t = prq_pkg::tid_t'($urandom_range(0, prq_pkg::NUM_TASKS - 1));
    for (int i = 0; i < prq_pkg::NUM_TASKS && task_queued[t]; i++) t = t + 1'b1;
    return t;
  endfunction

  function automatic prq_pkg::tid_t pick_queued_task();
    prq_pkg::tid_t t;
    t = prq_pkg::tid_t'($urandom_range(0, prq_pkg::NUM_TASKS - 1));
    for (int i = 0; i < prq_pkg::NUM_TASKS && !task_queued[t]; i++) t = t + 1'b1;
    return t;
  endfunction

  function automatic prq_pkg::level_t pick_busy_level();
    prq_pkg::level_t lv;
    lv = prq_pkg::level_t'($urandom_range(0, prq_pkg::NUM_LEVELS - 1));
    for (int i = 0; i < prq_pkg::NUM_LEVELS && lane_tasks[lv].size() == 0; i++) begin
      lv = lv + 1'b1;
    end
    return lv;
  endfunction

  function automatic prq_pkg::tid_t any_task();
    return prq_pkg::tid_t'($urandom_range(0, prq_pkg::NUM_TASKS - 1));
  endfunction

  function automatic prq_pkg::level_t any_level();
    return prq_pkg::level_t'($urandom_range(0, prq_pkg::NUM_LEVELS - 1));
  endfunction

  function automatic int draw_idle(logic quiet);
    return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
  endfunction

  // ---------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------
  int         sent_count = 0;
  int         send_gap   = 0;
  logic       send_free;
  sched_req_t next_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      send_gap  = 0;
    end else begin
      send_free = !drv_valid;
      // beat taken: draw the gap before the next one
      if (drv_valid && req_bus.ready) begin
        sent_count++;
        send_gap  = draw_idle(((sent_count / 50) % 4) == 3);
        send_free = 1'b1;
      end
      if (send_free) begin
        if (send_gap == 0 && pending_reqs.size() > 0) begin
          next_req  = pending_reqs.pop_front();
          drv_valid <= 1'b1;
          drv_kind  <= next_req.kind;
          drv_task  <= next_req.task_id;
          drv_level <= next_req.level;
        end else begin
          drv_valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: predicts on request beats, checks response beats
  // ---------------------------------------------------------------
  sched_result_t             expected_results [$];
  sched_result_t             want;
  int                        result_count   = 0;
  int                        mismatch_count = 0;
  int                        recv_stall     = 0;
  int                        push_count     = 0;
  int                        miss_count     = 0;
  logic [prq_pkg::MAP_W-1:0] levels_seen    = '0;

  task automatic report_mismatch(string field, longint unsigned got,
                                 longint unsigned exp_val);
    $display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
             $realtime, result_count, field, got, exp_val);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_results.push_back(
          schedule_step(req_bus.kind, req_bus.task_id, req_bus.level));
        if (req_bus.kind == prq_pkg::KIND_PUSH) push_count++;
      end
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("beat with nothing predicted, busy_levels",
                          64'(rsp_bus.busy_levels), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (rsp_bus.found !== want.found)
            report_mismatch("found", 64'(rsp_bus.found), 64'(want.found));
          if (rsp_bus.out_task !== want.out_task)
            report_mismatch("out_task", 64'(rsp_bus.out_task), 64'(want.out_task));
          if (rsp_bus.out_level !== want.out_level)
            report_mismatch("out_level", 64'(rsp_bus.out_level), 64'(want.out_level));
          if (rsp_bus.busy_levels !== want.busy)
            report_mismatch("busy_levels", 64'(rsp_bus.busy_levels), 64'(want.busy));
          if (!want.found) miss_count++;
          levels_seen |= want.busy;
        end
        result_count++;
        recv_stall = draw_idle(((result_count / 50) % 4) == 1);
      end
      // response stall
      if (recv_stall > 0) begin
        recv_stall--;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // run limit
  // ---------------------------------------------------------------
  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due",
               cycle_count, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    int              pick;
    prq_pkg::level_t lv;

    // falling edge applies the asynchronous reset
    rst_ni <= 1'b0;

    for (int i = 0; i < prq_pkg::NUM_LEVELS; i++) begin
      lvl_newest[i] = '0;
      lvl_oldest[i] = '0;
    end
    for (int i = 0; i < prq_pkg::NUM_TASKS; i++) begin
      next_link[i]   = '0;
      task_queued[i] = 1'b0;
    end
    ready_map = '0;

    // directed: empty pops, field extremes, fifo order, ignored code,
    // repeated push of a queued task
    add_request(prq_pkg::KIND_POP_TOP,   7'd127, 5'd31);
    add_request(prq_pkg::KIND_POP_LEVEL, 7'd127, 5'd31);
    add_request(prq_pkg::KIND_PUSH,      7'd127, 5'd31);
    add_request(prq_pkg::KIND_PUSH,      7'd0,   5'd0);
    add_request(prq_pkg::KIND_PUSH,      7'd5,   5'd0);
    add_request(prq_pkg::KIND_POP_LEVEL, 7'd0,   5'd31);
    add_request(prq_pkg::KIND_POP_TOP,   7'd0,   5'd0);
    add_request(prq_pkg::KIND_POP_TOP,   7'd127, 5'd31);
    add_request(prq_pkg::KIND_POP_TOP,   7'd0,   5'd0);
    add_request(prq_pkg::KIND_PUSH,      7'd64,  5'd16);
    add_request(prq_pkg::KIND_PUSH,      7'd1,   5'd16);
    add_request(prq_pkg::KIND_PUSH,      7'd2,   5'd16);
    add_request(prq_pkg::KIND_POP_LEVEL, 7'd0,   5'd16);
    add_request(prq_pkg::KIND_PUSH,      7'd3,   5'd1);
    add_request(prq_pkg::KIND_POP_TOP,   7'd0,   5'd0);
    add_request(KIND_UNUSED,             7'd127, 5'd31);
    add_request(prq_pkg::KIND_POP_TOP,   7'd0,   5'd0);
    add_request(prq_pkg::KIND_POP_LEVEL, 7'd0,   5'd16);
    add_request(prq_pkg::KIND_POP_LEVEL, 7'd0,   5'd16);
    add_request(prq_pkg::KIND_PUSH,      7'd10,  5'd4);
    add_request(prq_pkg::KIND_PUSH,      7'd10,  5'd4);
    add_request(prq_pkg::KIND_POP_LEVEL, 7'd0,   5'd4);
    add_request(prq_pkg::KIND_POP_LEVEL, 7'd0,   5'd4);
    add_request(prq_pkg::KIND_PUSH,      7'd42,  5'd21);
    add_request(prq_pkg::KIND_PUSH,      7'd85,  5'd10);

    // random: mostly sound push/pop traffic, some ignored codes and repeats, and periodic drains
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = int'($urandom_range(0, 99));
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        while (queued_total > 0) begin
          add_request(prq_pkg::KIND_POP_TOP, any_task(), any_level());
        end
        add_request(prq_pkg::KIND_POP_TOP, any_task(), any_level());
      end else if (pick < 45 && queued_total < MAX_QUEUED) begin
        lv = $urandom_range(0, 1) ? any_level() : prq_pkg::level_t'($urandom_range(0, 3));
        add_request(prq_pkg::KIND_PUSH, pick_idle_task(), lv);
      end else if (pick < 70) begin
        add_request(prq_pkg::KIND_POP_TOP, any_task(), any_level());
      end else if (pick < 92) begin
        lv = ($urandom_range(0, 3) != 0) ? pick_busy_level() : any_level();
        add_request(prq_pkg::KIND_POP_LEVEL, any_task(), lv);
      end else if (pick < 96) begin
        add_request(KIND_UNUSED, any_task(), any_level());
      end else if (queued_total > 0) begin
        add_request(prq_pkg::KIND_PUSH, pick_queued_task(), any_level());
      end else begin
        add_request(prq_pkg::KIND_POP_LEVEL, any_task(), any_level());
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all requests sent and all results back
    do begin
      @(posedge clk_i);
    end while (pending_reqs.size() > 0 || drv_valid || expected_results.size() > 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d requests sent, %0d pushes, %0d results checked, %0d found nothing",
             sent_count, push_count, result_count, miss_count);
    $display("levels occupied at some point: 0x%08h, %0d mismatches",
             levels_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
